FILE: design/nfa_longest_prefix_matcher_assert.svh
// assertion macros for the nfa longest prefix matcher
`ifndef NFA_LONGEST_PREFIX_MATCHER_ASSERT_SVH
`define NFA_LONGEST_PREFIX_MATCHER_ASSERT_SVH

// checks an implication on every clock edge out of reset
`define NLPM_CHECK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("nlpm check failed");

// checks a condition that must hold on every clock edge out of reset
`define NLPM_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("nlpm invariant failed");

`endif

FILE: design/nlpm_pkg.sv
// shared types and constants of the nfa longest prefix matcher
`default_nettype none
package nlpm_pkg;

    localparam int unsigned FIELD_IW = 6;
    localparam int unsigned FIELD_SW = 8;
    localparam int unsigned LEN_W    = 17;
    localparam int unsigned POS_W    = 16;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_MATCH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_CLOS,
        ST_STRIP,
        ST_FIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [FIELD_SW-1:0] sym;
        logic [FIELD_IW-1:0] target;
        logic [FIELD_IW-1:0] eps1;
        logic                eps1_ok;
        logic [FIELD_IW-1:0] eps2;
        logic                eps2_ok;
        logic                acc;
    } t_entry;

    typedef struct packed {
        logic                en;
        logic [FIELD_IW-1:0] idx;
        t_entry              ent;
    } t_wr;

endpackage
`default_nettype wire

FILE: design/nfa_longest_prefix_matcher.sv
// top level of the nfa longest prefix matcher
//
// channel   handshake                  payload
// input     i_valid / o_ready          i_req_type, node entry fields, i_in_symbol, i_last_symbol
// config    i_cfg_valid / o_cfg_ready  i_cfg_start_node
// output    o_valid / i_ready          o_match_length
//
// a table write is taken while idle; each symbol is one step sweep and then closure sweeps
// over the node table memory (one read port), repeated until no new node is reached
// the first symbol of a string adds one more closure for the start node
// synchronous active-low reset clears control state; the node table has no reset
// a result waits in the output register; a new result waits in the OUT state while it is still full
`default_nettype none
module nfa_longest_prefix_matcher #(
    parameter int unsigned     NODES       = 64,
    parameter int unsigned     SYMBOL_BITS = 8,
    parameter longint unsigned MAX_LEN     = 65535
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic                                i_req_type,
    input  wire logic [nlpm_pkg::FIELD_IW-1:0]       i_node_index,
    input  wire logic [nlpm_pkg::FIELD_SW-1:0]       i_node_symbol,
    input  wire logic [nlpm_pkg::FIELD_IW-1:0]       i_node_target,
    input  wire logic [nlpm_pkg::FIELD_IW-1:0]       i_eps_first,
    input  wire logic                                i_eps_first_valid,
    input  wire logic [nlpm_pkg::FIELD_IW-1:0]       i_eps_second,
    input  wire logic                                i_eps_second_valid,
    input  wire logic                                i_node_accepting,
    input  wire logic [nlpm_pkg::FIELD_SW-1:0]       i_in_symbol,
    input  wire logic                                i_last_symbol,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [nlpm_pkg::FIELD_IW-1:0]       i_cfg_start_node,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [nlpm_pkg::LEN_W-1:0]        o_match_length
);
    import nlpm_pkg::*;

    t_wr                        w_wr;
    logic [$clog2(NODES)-1:0]   w_rd_addr;
    t_entry                     w_rd_data;
    logic [NODES-1:0]           w_eps_vec;
    logic [NODES-1:0]           w_acc_vec;

    nlpm_table #(
        .NODES (NODES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .o_eps_vec (w_eps_vec),
        .o_acc_vec (w_acc_vec)
    );

    nlpm_engine #(
        .NODES       (NODES),
        .SYMBOL_BITS (SYMBOL_BITS),
        .MAX_LEN     (MAX_LEN)
    ) u_engine (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_req_type         (i_req_type),
        .i_node_index       (i_node_index),
        .i_node_symbol      (i_node_symbol),
        .i_node_target      (i_node_target),
        .i_eps_first        (i_eps_first),
        .i_eps_first_valid  (i_eps_first_valid),
        .i_eps_second       (i_eps_second),
        .i_eps_second_valid (i_eps_second_valid),
        .i_node_accepting   (i_node_accepting),
        .i_in_symbol        (i_in_symbol),
        .i_last_symbol      (i_last_symbol),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_start_node   (i_cfg_start_node),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_match_length     (o_match_length),
        .o_wr               (w_wr),
        .o_rd_addr          (w_rd_addr),
        .i_rd_data          (w_rd_data),
        .i_eps_vec          (w_eps_vec),
        .i_acc_vec          (w_acc_vec)
    );
endmodule
`default_nettype wire

FILE: design/nlpm_table.sv
// node table memory with per-node epsilon and accepting flag vectors
`default_nettype none
module nlpm_table #(
    parameter int unsigned NODES = 64
) (
    input  wire logic                        i_clk,
    input  wire nlpm_pkg::t_wr               i_wr,
    input  wire logic [$clog2(NODES)-1:0]    i_rd_addr,
    output nlpm_pkg::t_entry                 o_rd_data,
    output logic [NODES-1:0]                 o_eps_vec,
    output logic [NODES-1:0]                 o_acc_vec
);
    import nlpm_pkg::*;

    localparam int unsigned IW = $clog2(NODES);
    // one bit wider than any index so that NODES itself fits in the compare
    localparam int unsigned TW = ((IW > FIELD_IW) ? IW : FIELD_IW) + 1;

    t_entry           r_mem [NODES];
    t_entry           r_rd;
    logic [NODES-1:0] r_eps;
    logic [NODES-1:0] r_acc;
    logic [TW-1:0]    w_idx;
    logic             w_in_range;

    assign w_idx      = TW'(i_wr.idx);
    assign w_in_range = (w_idx < TW'(NODES));

    always_ff @(posedge i_clk) begin
        if (i_wr.en && w_in_range) begin
            r_mem[w_idx[IW-1:0]] <= i_wr.ent;
            r_eps[w_idx[IW-1:0]] <= i_wr.ent.eps1_ok | i_wr.ent.eps2_ok;
            r_acc[w_idx[IW-1:0]] <= i_wr.ent.acc;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;
    assign o_eps_vec = r_eps;
    assign o_acc_vec = r_acc;
endmodule
`default_nettype wire

FILE: design/nlpm_engine.sv
// sequencer that sweeps the node table for symbol steps and epsilon closure
`default_nettype none
module nlpm_engine #(
    parameter int unsigned     NODES       = 64,
    parameter int unsigned     SYMBOL_BITS = 8,
    parameter longint unsigned MAX_LEN     = 65535
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic                                i_req_type,
    input  wire logic [nlpm_pkg::FIELD_IW-1:0]       i_node_index,
    input  wire logic [nlpm_pkg::FIELD_SW-1:0]       i_node_symbol,
    input  wire logic [nlpm_pkg::FIELD_IW-1:0]       i_node_target,
    input  wire logic [nlpm_pkg::FIELD_IW-1:0]       i_eps_first,
    input  wire logic                                i_eps_first_valid,
    input  wire logic [nlpm_pkg::FIELD_IW-1:0]       i_eps_second,
    input  wire logic                                i_eps_second_valid,
    input  wire logic                                i_node_accepting,
    input  wire logic [nlpm_pkg::FIELD_SW-1:0]       i_in_symbol,
    input  wire logic                                i_last_symbol,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [nlpm_pkg::FIELD_IW-1:0]       i_cfg_start_node,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [nlpm_pkg::LEN_W-1:0]        o_match_length,
    output nlpm_pkg::t_wr                            o_wr,
    output logic [$clog2(NODES)-1:0]                 o_rd_addr,
    input  wire nlpm_pkg::t_entry                    i_rd_data,
    input  wire logic [NODES-1:0]                    i_eps_vec,
    input  wire logic [NODES-1:0]                    i_acc_vec
);
    import nlpm_pkg::*;

    localparam int unsigned IW = $clog2(NODES);
    // one bit wider than any index so that NODES itself fits in the compare
    localparam int unsigned TW = ((IW > FIELD_IW) ? IW : FIELD_IW) + 1;
    localparam int unsigned CW = IW + 1;
    localparam logic [FIELD_SW-1:0] SYM_MASK =
        (SYMBOL_BITS >= FIELD_SW) ? {FIELD_SW{1'b1}} : FIELD_SW'((1 << SYMBOL_BITS) - 1);
    localparam logic [POS_W-1:0] POS_CAP =
        (MAX_LEN > 65535) ? {POS_W{1'b1}} : POS_W'(MAX_LEN);

    t_state                    r_state, n_state;
    logic [NODES-1:0]          r_set, n_set;
    logic [NODES-1:0]          r_next, n_next;
    logic [CW-1:0]             r_idx, n_idx;
    logic                      r_changed, n_changed;
    logic                      r_phase, n_phase;
    logic [FIELD_SW-1:0]       r_sym, n_sym;
    logic                      r_last, n_last;
    logic signed [LEN_W-1:0]   r_best, n_best;
    logic [POS_W-1:0]          r_pos, n_pos;
    logic                      r_in_string, n_in_string;
    logic                      r_o_valid, n_o_valid;
    logic signed [LEN_W-1:0]   r_o_len, n_o_len;
    logic [FIELD_IW-1:0]       r_start;
    logic                      r_rd_vld;
    logic [IW-1:0]             r_rd_idx;

    logic          w_issue, w_accept, w_rd_last;
    logic [TW-1:0] w_tgt, w_e1, w_e2, w_st;
    logic [POS_W-1:0] w_pos_inc;

    assign w_accept  = i_valid && o_ready;
    assign w_issue   = ((r_state == ST_STEP) || (r_state == ST_CLOS)) && (r_idx < CW'(NODES));
    assign w_rd_last = r_rd_vld && (r_rd_idx == IW'(NODES - 1));
    assign w_tgt     = TW'(i_rd_data.target);
    assign w_e1      = TW'(i_rd_data.eps1);
    assign w_e2      = TW'(i_rd_data.eps2);
    assign w_st      = TW'(r_start);
    assign w_pos_inc = (r_pos < POS_CAP) ? r_pos + 1'b1 : r_pos;

    assign o_ready        = (r_state == ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_o_valid;
    assign o_match_length = r_o_len;
    assign o_rd_addr      = r_idx[IW-1:0];

    always_comb begin
        o_wr.en              = w_accept && (i_req_type == REQ_WRITE);
        o_wr.idx             = i_node_index;
        o_wr.ent.sym         = i_node_symbol & SYM_MASK;
        o_wr.ent.target      = i_node_target;
        o_wr.ent.eps1        = i_eps_first;
        o_wr.ent.eps1_ok     = i_eps_first_valid;
        o_wr.ent.eps2        = i_eps_second;
        o_wr.ent.eps2_ok     = i_eps_second_valid;
        o_wr.ent.acc         = i_node_accepting;
    end

    always_comb begin
        n_state     = r_state;
        n_set       = r_set;
        n_next      = r_next;
        n_idx       = r_idx;
        n_changed   = r_changed;
        n_phase     = r_phase;
        n_sym       = r_sym;
        n_last      = r_last;
        n_best      = r_best;
        n_pos       = r_pos;
        n_in_string = r_in_string;
        n_o_valid   = r_o_valid;
        n_o_len     = r_o_len;
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end
        if (w_issue) begin
            n_idx = r_idx + 1'b1;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_req_type == REQ_MATCH)) begin
                    n_sym     = i_in_symbol & SYM_MASK;
                    n_last    = i_last_symbol;
                    n_idx     = '0;
                    n_changed = 1'b0;
                    n_next    = '0;
                    if (!r_in_string) begin
                        n_set = '0;
                        if (w_st < TW'(NODES)) begin
                            n_set[w_st[IW-1:0]] = 1'b1;
                        end
                        n_best      = -LEN_W'(1);
                        n_pos       = '0;
                        n_in_string = 1'b1;
                        n_phase     = 1'b0;
                        n_state     = ST_CLOS;
                    end else begin
                        n_state = ST_STEP;
                    end
                end
            end
            ST_STEP: begin
                if (r_rd_vld && r_set[r_rd_idx] && (r_sym != '0)
                        && (i_rd_data.sym == r_sym) && (w_tgt < TW'(NODES))) begin
                    n_next[w_tgt[IW-1:0]] = 1'b1;
                end
                if (w_rd_last) begin
                    n_set     = n_next;
                    n_idx     = '0;
                    n_changed = 1'b0;
                    n_phase   = 1'b1;
                    n_state   = ST_CLOS;
                end
            end
            ST_CLOS: begin
                // in-place sweep, repeated until nothing new is reached
                if (r_rd_vld && r_set[r_rd_idx]) begin
                    if (i_rd_data.eps1_ok && (w_e1 < TW'(NODES)) && !n_set[w_e1[IW-1:0]]) begin
                        n_set[w_e1[IW-1:0]] = 1'b1;
                        n_changed           = 1'b1;
                    end
                    if (i_rd_data.eps2_ok && (w_e2 < TW'(NODES)) && !n_set[w_e2[IW-1:0]]) begin
                        n_set[w_e2[IW-1:0]] = 1'b1;
                        n_changed           = 1'b1;
                    end
                end
                if (w_rd_last) begin
                    n_idx = '0;
                    if (n_changed) begin
                        n_changed = 1'b0;
                    end else begin
                        n_state = ST_STRIP;
                    end
                end
            end
            ST_STRIP: begin
                n_set  = r_set & ~i_eps_vec;
                n_idx  = '0;
                n_next = '0;
                n_state = r_phase ? ST_FIN : ST_STEP;
            end
            ST_FIN: begin
                n_pos = w_pos_inc;
                if (|(r_set & i_acc_vec)) begin
                    n_best = $signed({1'b0, w_pos_inc});
                end
                if (r_last) begin
                    n_in_string = 1'b0;
                    n_state     = ST_OUT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (!r_o_valid) begin
                    n_o_valid = 1'b1;
                    n_o_len   = r_best;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_set       <= '0;
            r_best      <= -LEN_W'(1);
            r_pos       <= '0;
            r_in_string <= 1'b0;
            r_o_valid   <= 1'b0;
            r_start     <= '0;
            r_rd_vld    <= 1'b0;
            r_idx       <= '0;
            r_changed   <= 1'b0;
            r_phase     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_set       <= n_set;
            r_best      <= n_best;
            r_pos       <= n_pos;
            r_in_string <= n_in_string;
            r_o_valid   <= n_o_valid;
            r_rd_vld    <= w_issue;
            r_idx       <= n_idx;
            r_changed   <= n_changed;
            r_phase     <= n_phase;
            if (i_cfg_valid && o_cfg_ready) begin
                r_start <= i_cfg_start_node;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_next   <= n_next;
        r_sym    <= n_sym;
        r_last   <= n_last;
        r_o_len  <= n_o_len;
        r_rd_idx <= r_idx[IW-1:0];
    end

`include "nfa_longest_prefix_matcher_assert.svh"

    `NLPM_CHECK(a_out_hold, (r_o_valid && !i_ready) |=> r_o_valid)
    `NLPM_CHECK(a_last_reports, (r_state == ST_FIN && r_last) |=> (r_state == ST_OUT))
    `NLPM_ALWAYS(a_best_le_pos, r_best <= $signed({1'b0, r_pos}))
    `NLPM_ALWAYS(a_pos_cap, r_pos <= POS_CAP)
endmodule
`default_nettype wire
